// ===== rtl/svpw_pkg.sv =====
// ----------------------------------------------------------------------------
// svpw_pkg
// Shared types and constants for the servo command to pulse width block.
// ----------------------------------------------------------------------------
`default_nettype none

package svpw_pkg;

    // Widths of the payload fields.
    localparam int unsigned PULSE_W  = 12;
    localparam int unsigned CMD_W    = 12;
    localparam int unsigned ROT_W    = 11;
    localparam int unsigned SPEED_W  = 10;
    localparam int unsigned SCALE_W  = 16;
    localparam int unsigned Q_SHIFT  = 12;

    // Exact Q12 pulse before clamping, signed.
    localparam int unsigned Q_W      = 29;
    // Clamped Q12 pulse, always in 0..4095 us.
    localparam int unsigned QC_W     = PULSE_W + Q_SHIFT;

    localparam logic [PULSE_W-1:0] RST_PULSE_US = 12'd1500;
    localparam logic [QC_W-1:0]    Q_HALF       = 24'd2048;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_POSITION = 2'd0,
        KIND_VELOCITY = 2'd1,
        KIND_ACTIVATE = 2'd2,
        KIND_POWER_OFF = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_POSITION = 2'd1,
        MODE_VELOCITY = 2'd2,
        MODE_NONE_ALT = 2'd3
    } servo_mode_t;

    typedef enum logic [1:0] {
        STATUS_STOPPED  = 2'd0,
        STATUS_POSITION = 2'd1,
        STATUS_VELOCITY = 2'd2,
        STATUS_IDLE     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERVO_MODE     = 3'd0,
        REG_PULSE_MIN      = 3'd1,
        REG_PULSE_MAX      = 3'd2,
        REG_MAX_ROTATION   = 3'd3,
        REG_MAX_SPEED      = 3'd4,
        REG_NEUTRAL        = 3'd5,
        REG_POSITION_SCALE = 3'd6,
        REG_VELOCITY_SCALE = 3'd7
    } cfg_reg_t;

    // Result item; the first field sits in the highest bits of tdata.
    typedef struct packed {
        status_t            status_code;
        logic               accepted;
        logic               power_on;
        logic [PULSE_W-1:0] pulse_width_us;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/servo_command_to_pulse_width.sv =====
// ----------------------------------------------------------------------------
// servo_command_to_pulse_width
// Maps position and velocity commands for one hobby servo port to a pulse
// width in microseconds, with supply enable and a status code per item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Transfer
//  s_*       in         tuser: kind, tdata: command_value        tvalid & tready
//  m_*       out        tdata: pulse, power, accepted, status    tvalid & tready
//  cfg_*     in         cfg_index, cfg_data                      cfg_valid & cfg_ready
//
// One item per cycle while the output is not stalled. An item is held in the
// input register and its result is registered in the output register.
// Clamps, one 12x17 multiply-add and rounding sit between the two registers,
// and pulse and supply update with the result, so the next item sees them.
// A stalled output holds the input register and s_tready falls. Reset empties
// both stages, loads the register defaults and sets 1500 us with supply off.
`default_nettype none

module servo_command_to_pulse_width (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Command stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,  // [11:0] command_value
    input  wire logic [1:0]                        s_tuser,  // [1:0] kind
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [11:0] pulse_width_us, [12] power_on, [13] accepted, [15:14] status_code
    output logic [15:0]                            m_tdata,
    // Register writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [svpw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [svpw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import svpw_pkg::*;

    // Configuration registers.
    servo_mode_t         mode_reg;
    logic [PULSE_W-1:0]  pulse_min_reg;
    logic [PULSE_W-1:0]  pulse_max_reg;
    logic [ROT_W-1:0]    max_rot_reg;
    logic [SPEED_W-1:0]  max_speed_reg;
    logic [PULSE_W-1:0]  neutral_reg;
    logic [SCALE_W-1:0]  pos_scale_reg;
    logic [SCALE_W-1:0]  vel_scale_reg;

    // Servo state.
    logic [PULSE_W-1:0]  pulse_reg;
    logic [PULSE_W-1:0]  pulse_next;
    logic                supply_reg;
    logic                supply_next;

    // Input register.
    logic                s1_valid_reg;
    kind_t               s1_kind_reg;
    logic signed [CMD_W-1:0] s1_value_reg;

    // Output register.
    logic                out_valid_reg;
    result_t             result_reg;
    result_t             result_next;

    logic                advance;
    logic                mode_pos;
    logic                mode_vel;
    logic                have_cmd;

    logic signed [CMD_W-1:0]  pos_target;
    logic signed [CMD_W-1:0]  vel_target;
    logic signed [CMD_W-1:0]  speed_lim;
    logic signed [CMD_W-1:0]  mul_op;
    logic [SCALE_W-1:0]       mul_scale;
    logic [PULSE_W-1:0]       base_us;
    logic signed [Q_W-1:0]    product;
    logic signed [Q_W-1:0]    q_raw;
    logic signed [Q_W-1:0]    q_lo;
    logic signed [Q_W-1:0]    q_hi;
    logic signed [Q_W-1:0]    q_clamped;
    logic [QC_W-1:0]          q_rounded;
    logic [PULSE_W-1:0]       cmd_pulse;

    // The stage moves forward when the output register is free or drains now.
    assign advance   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = result_reg;
    assign cfg_ready = 1'b1;

    assign mode_pos = (mode_reg == MODE_POSITION);
    assign mode_vel = (mode_reg == MODE_VELOCITY);
    assign have_cmd = (s1_kind_reg == KIND_POSITION && mode_pos) ||
                      (s1_kind_reg == KIND_VELOCITY && mode_vel);

    // Target clamps: position to 0..max rotation, velocity to +-max speed.
    assign speed_lim = $signed({2'b00, max_speed_reg});

    always_comb
    begin
        priority if (s1_value_reg[CMD_W-1])
        begin
            pos_target = '0;
        end
        else if (s1_value_reg[ROT_W-1:0] > max_rot_reg)
        begin
            pos_target = $signed({1'b0, max_rot_reg});
        end
        else
        begin
            pos_target = s1_value_reg;
        end

        priority if (s1_value_reg < -speed_lim)
        begin
            vel_target = -speed_lim;
        end
        else if (s1_value_reg > speed_lim)
        begin
            vel_target = speed_lim;
        end
        else
        begin
            vel_target = s1_value_reg;
        end
    end

    // One shared multiplier; base and scale follow the command kind.
    assign mul_op    = (s1_kind_reg == KIND_VELOCITY) ? vel_target : pos_target;
    assign mul_scale = (s1_kind_reg == KIND_VELOCITY) ? vel_scale_reg : pos_scale_reg;
    assign base_us   = (s1_kind_reg == KIND_VELOCITY) ? neutral_reg : pulse_min_reg;

    assign product = Q_W'(mul_op) * $signed(Q_W'({1'b0, mul_scale}));
    assign q_raw   = $signed({{(Q_W-QC_W){1'b0}}, base_us, {Q_SHIFT{1'b0}}}) + product;
    assign q_lo    = $signed({{(Q_W-QC_W){1'b0}}, pulse_min_reg, {Q_SHIFT{1'b0}}});
    assign q_hi    = $signed({{(Q_W-QC_W){1'b0}}, pulse_max_reg, {Q_SHIFT{1'b0}}});

    // Low bound first, then high bound; the result always lands in 0..4095 us.
    always_comb
    begin
        priority if (q_raw < q_lo)
        begin
            q_clamped = q_lo;
        end
        else if (q_raw > q_hi)
        begin
            q_clamped = q_hi;
        end
        else
        begin
            q_clamped = q_raw;
        end
    end

    assign q_rounded = q_clamped[QC_W-1:0] + Q_HALF;
    assign cmd_pulse = q_rounded[QC_W-1:Q_SHIFT];

    // State update and result for the item in the input register.
    always_comb
    begin
        pulse_next  = pulse_reg;
        supply_next = supply_reg;
        result_next = '0;

        unique case (s1_kind_reg)
            KIND_ACTIVATE:
            begin
                result_next.accepted = 1'b1;
                if (mode_pos)
                begin
                    supply_next = 1'b1;
                    pulse_next  = pulse_min_reg;
                end
                else if (mode_vel)
                begin
                    supply_next = 1'b1;
                    pulse_next  = RST_PULSE_US;
                end
                else
                begin
                    supply_next = 1'b0;
                    pulse_next  = RST_PULSE_US;
                end
            end
            KIND_POWER_OFF:
            begin
                result_next.accepted = 1'b1;
                supply_next          = 1'b0;
            end
            KIND_POSITION, KIND_VELOCITY:
            begin
                if (have_cmd && cmd_pulse != pulse_reg)
                begin
                    result_next.accepted = 1'b1;
                    supply_next          = 1'b1;
                    pulse_next           = cmd_pulse;
                end
            end
            default:
            begin
                result_next.accepted = 1'b0;
            end
        endcase

        result_next.pulse_width_us = pulse_next;
        result_next.power_on       = supply_next;
        if (!supply_next)
        begin
            result_next.status_code = STATUS_STOPPED;
        end
        else if (mode_pos)
        begin
            result_next.status_code = STATUS_POSITION;
        end
        else if (mode_vel)
        begin
            result_next.status_code = STATUS_VELOCITY;
        end
        else
        begin
            result_next.status_code = STATUS_IDLE;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NONE;
            pulse_min_reg <= '0;
            pulse_max_reg <= '0;
            max_rot_reg   <= '0;
            max_speed_reg <= '0;
            neutral_reg   <= RST_PULSE_US;
            pos_scale_reg <= '0;
            vel_scale_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SERVO_MODE:     mode_reg      <= servo_mode_t'(cfg_data[1:0]);
                REG_PULSE_MIN:      pulse_min_reg <= cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:      pulse_max_reg <= cfg_data[PULSE_W-1:0];
                REG_MAX_ROTATION:   max_rot_reg   <= cfg_data[ROT_W-1:0];
                REG_MAX_SPEED:      max_speed_reg <= cfg_data[SPEED_W-1:0];
                REG_NEUTRAL:        neutral_reg   <= cfg_data[PULSE_W-1:0];
                REG_POSITION_SCALE: pos_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_VELOCITY_SCALE: vel_scale_reg <= cfg_data[SCALE_W-1:0];
                default:            mode_reg      <= mode_reg;
            endcase
        end
    end

    // Control: pipeline valids and servo state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pulse_reg     <= RST_PULSE_US;
            supply_reg    <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pulse_reg     <= pulse_next;
                supply_reg    <= supply_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_kind_reg  <= kind_t'(s_tuser);
            s1_value_reg <= $signed(s_tdata[CMD_W-1:0]);
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // The waiting result always mirrors the servo state.
    a_result_matches_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.pulse_width_us == pulse_reg) &&
                          (result_reg.power_on == supply_reg))
        else $error("result register out of step with servo state");

    // A rejected command leaves pulse and supply untouched.
    a_reject_keeps_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && !result_next.accepted) |=>
            (pulse_reg == $past(pulse_reg)) && (supply_reg == $past(supply_reg)))
        else $error("rejected command changed servo state");

    // Power off always leaves the supply disabled and reports stopped.
    a_power_off: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && s1_kind_reg == KIND_POWER_OFF) |=>
            !supply_reg && (result_reg.status_code == STATUS_STOPPED))
        else $error("power off did not disable the supply");

endmodule

`default_nettype wire
